FILE: src/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types and constants of the colour palette RAM port: register select
// codes, access kinds, index register layout and palette unit control.
// ----------------------------------------------------------------------------
`default_nettype none

package cpr_pkg;

	localparam int unsigned PAL_DEPTH = 32;
	localparam int unsigned ENTRY_W   = $clog2(PAL_DEPTH);
	localparam int unsigned FIELD_W   = ENTRY_W + 1;
	localparam int unsigned HIGH_W    = 7;

	localparam logic [7:0] INDEX_KEEP = 8'hBF;
	localparam int unsigned AUTO_INC_BIT = 7;
	localparam int unsigned HIGH_SEL_BIT = 0;

	typedef enum logic [1:0] {
		SEL_BG_INDEX  = 2'd0,
		SEL_BG_DATA   = 2'd1,
		SEL_OBJ_INDEX = 2'd2,
		SEL_OBJ_DATA  = 2'd3
	} reg_sel_t;

	typedef enum logic {
		KIND_READ  = 1'b0,
		KIND_WRITE = 1'b1
	} kind_t;

	typedef struct packed {
		logic wr_index;
		logic wr_data;
	} pal_op_t;

	typedef struct packed {
		logic [7:0] index;
		logic [7:0] data;
	} pal_view_t;

endpackage

`default_nettype wire

FILE: src/cpr_req_if.sv
// ----------------------------------------------------------------------------
// cpr_req_if
// Request channel of the palette port: access kind, register select and the
// byte to write, with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpr_req_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [1:0] reg_select;
	logic [7:0] write_data;

	modport source (output valid, kind, reg_select, write_data, input ready);
	modport sink (input valid, kind, reg_select, write_data, output ready);
endinterface

`default_nettype wire

FILE: src/cpr_rsp_if.sv
// ----------------------------------------------------------------------------
// cpr_rsp_if
// Response channel of the palette port: the byte read back after each
// request, with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpr_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;

	modport source (output valid, read_data, input ready);
	modport sink (input valid, read_data, output ready);
endinterface

`default_nettype wire

FILE: src/color_palette_ram_port.sv
// ----------------------------------------------------------------------------
// color_palette_ram_port
// Background and object colour palette access through index/data registers
// with auto-increment.
// ----------------------------------------------------------------------------
// Each request is captured in an input register, applied to the addressed
// palette from there once the response register can take its read-back byte,
// and that byte is held in the response register until taken. One request is
// accepted every cycle while responses are taken. A stalled response holds
// back one further request in the input register. Both palettes and all four
// registers are zero after reset, with no clearing pass.
`default_nettype none

module color_palette_ram_port (
	input  wire logic clk,
	input  wire logic arst_n,
	cpr_req_if.sink   req,
	cpr_rsp_if.source rsp
);

	logic                req_v_s1;
	cpr_pkg::kind_t      kind_s1;
	cpr_pkg::reg_sel_t   sel_s1;
	logic [7:0]          wdata_s1;

	logic                rsp_v_q;
	logic [7:0]          rsp_data_q;

	logic                advance;
	logic                go;
	logic                wr;
	cpr_pkg::pal_op_t    bg_op;
	cpr_pkg::pal_op_t    obj_op;
	cpr_pkg::pal_view_t  bg_view;
	cpr_pkg::pal_view_t  obj_view;
	logic [7:0]          result;

	assign advance   = !rsp_v_q || rsp.ready;
	assign req.ready = !req_v_s1 || advance;
	assign go        = req_v_s1 && advance;
	assign wr        = go && (kind_s1 == cpr_pkg::KIND_WRITE);

	assign bg_op.wr_index  = wr && (sel_s1 == cpr_pkg::SEL_BG_INDEX);
	assign bg_op.wr_data   = wr && (sel_s1 == cpr_pkg::SEL_BG_DATA);
	assign obj_op.wr_index = wr && (sel_s1 == cpr_pkg::SEL_OBJ_INDEX);
	assign obj_op.wr_data  = wr && (sel_s1 == cpr_pkg::SEL_OBJ_DATA);

	cpr_palette u_bg (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (bg_op),
		.write_data (wdata_s1),
		.view_nxt   (bg_view)
	);

	cpr_palette u_obj (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (obj_op),
		.write_data (wdata_s1),
		.view_nxt   (obj_view)
	);

	always_comb begin
		case (sel_s1)
			cpr_pkg::SEL_BG_INDEX:  result = bg_view.index;
			cpr_pkg::SEL_BG_DATA:   result = bg_view.data;
			cpr_pkg::SEL_OBJ_INDEX: result = obj_view.index;
			cpr_pkg::SEL_OBJ_DATA:  result = obj_view.data;
			default:                result = bg_view.index;
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_v_s1 <= 1'b0;
		end else if (req.ready) begin
			req_v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_s1  <= cpr_pkg::kind_t'(req.kind);
			sel_s1   <= cpr_pkg::reg_sel_t'(req.reg_select);
			wdata_s1 <= req.write_data;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (advance) begin
			rsp_v_q <= req_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rsp_data_q <= result;
		end
	end

	assign rsp.valid     = rsp_v_q;
	assign rsp.read_data = rsp_data_q;

endmodule

`default_nettype wire

FILE: src/cpr_palette.sv
// ----------------------------------------------------------------------------
// cpr_palette
// One palette: index register, data register and the entry store, kept as
// separate low and high byte planes so a data write touches one byte only.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_palette (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cpr_pkg::pal_op_t   op,
	input  wire logic [7:0]         write_data,
	output      cpr_pkg::pal_view_t view_nxt
);

	logic [7:0]                   index_q;
	logic [7:0]                   data_q;
	logic [7:0]                   lo_q [cpr_pkg::PAL_DEPTH];
	logic [cpr_pkg::HIGH_W-1:0]   hi_q [cpr_pkg::PAL_DEPTH];

	logic                         auto_inc;
	logic [cpr_pkg::FIELD_W-1:0]  field_inc;
	logic [7:0]                   index_inc;
	logic [cpr_pkg::FIELD_W-1:0]  load_sel;
	logic [cpr_pkg::ENTRY_W-1:0]  load_ent;
	logic [cpr_pkg::ENTRY_W-1:0]  cur_ent;
	logic [7:0]                   load_byte;

	assign auto_inc  = index_q[cpr_pkg::AUTO_INC_BIT];
	assign field_inc = index_q[cpr_pkg::FIELD_W-1:0]
		+ {{(cpr_pkg::FIELD_W-1){1'b0}}, 1'b1};
	assign index_inc = {index_q[7:cpr_pkg::FIELD_W], field_inc};
	assign cur_ent   = index_q[cpr_pkg::FIELD_W-1:1];

	assign load_sel  = op.wr_index ? write_data[cpr_pkg::FIELD_W-1:0] : field_inc;
	assign load_ent  = load_sel[cpr_pkg::FIELD_W-1:1];
	assign load_byte = load_sel[cpr_pkg::HIGH_SEL_BIT]
		? {{(8-cpr_pkg::HIGH_W){1'b0}}, hi_q[load_ent]}
		: lo_q[load_ent];

	always_comb begin
		view_nxt.index = index_q;
		view_nxt.data  = data_q;
		if (op.wr_index) begin
			view_nxt.index = write_data & cpr_pkg::INDEX_KEEP;
			view_nxt.data  = load_byte;
		end else if (op.wr_data) begin
			if (auto_inc) begin
				view_nxt.index = index_inc;
				view_nxt.data  = load_byte;
			end else begin
				view_nxt.data  = write_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
			data_q  <= '0;
		end else begin
			index_q <= view_nxt.index;
			data_q  <= view_nxt.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cpr_pkg::PAL_DEPTH; i++) begin
				lo_q[i] <= '0;
				hi_q[i] <= '0;
			end
		end else if (op.wr_data) begin
			if (index_q[cpr_pkg::HIGH_SEL_BIT]) begin
				hi_q[cur_ent] <= write_data[cpr_pkg::HIGH_W-1:0];
			end else begin
				lo_q[cur_ent] <= write_data;
			end
		end
	end

endmodule

`default_nettype wire

FILE: tb/color_palette_ram_port_tb.sv
// ----------------------------------------------------------------------------
// color_palette_ram_port_tb
// Self-checking bench for the palette index/data port. A table of directed
// requests covers reset values, index bit 6 dropping, high-byte masking and
// the auto-increment wrap. Random streams of index and data writes then
// follow, with read-back and noise mixed in, and random idling on both
// channels. Each response is checked against the table or a palette model.
// ----------------------------------------------------------------------------

module color_palette_ram_port_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_REQUESTS = 1900;
	localparam int DIR_COUNT = 23;

	typedef struct packed {
		cpr_pkg::kind_t    kind;
		cpr_pkg::reg_sel_t sel;
		logic [7:0]        wdata;
		logic              typed;
		logic [7:0]        want;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
		'{cpr_pkg::KIND_READ,  cpr_pkg::SEL_BG_INDEX,  8'h00, 1'b1, 8'h00},
		'{cpr_pkg::KIND_READ,  cpr_pkg::SEL_BG_DATA,   8'h00, 1'b1, 8'h00},
		'{cpr_pkg::KIND_READ,  cpr_pkg::SEL_OBJ_INDEX, 8'hFF, 1'b1, 8'h00},
		'{cpr_pkg::KIND_READ,  cpr_pkg::SEL_OBJ_DATA,  8'hFF, 1'b1, 8'h00},
		'{cpr_pkg::KIND_WRITE, cpr_pkg::SEL_BG_INDEX,  8'hFF, 1'b1, 8'hBF},
		'{cpr_pkg::KIND_WRITE, cpr_pkg::SEL_BG_DATA,   8'hFF, 1'b0, 8'h00},
		'{cpr_pkg::KIND_READ,  cpr_pkg::SEL_BG_INDEX,  8'h00, 1'b1, 8'h80},
		'{cpr_pkg::KIND_WRITE, cpr_pkg::SEL_BG_INDEX,  8'h3F, 1'b1, 8'h3F},
		'{cpr_pkg::KIND_READ,  cpr_pkg::SEL_BG_DATA,   8'h00, 1'b0, 8'h00},
		'{cpr_pkg::KIND_WRITE, cpr_pkg::SEL_BG_INDEX,  8'h01, 1'b1, 8'h01},
		'{cpr_pkg::KIND_WRITE, cpr_pkg::SEL_BG_DATA,   8'hFF, 1'b1, 8'hFF},
		'{cpr_pkg::KIND_READ,  cpr_pkg::SEL_BG_DATA,   8'h00, 1'b1, 8'hFF},
		'{cpr_pkg::KIND_WRITE, cpr_pkg::SEL_BG_INDEX,  8'h01, 1'b1, 8'h01},
		'{cpr_pkg::KIND_READ,  cpr_pkg::SEL_BG_DATA,   8'h00, 1'b0, 8'h00},
		'{cpr_pkg::KIND_WRITE, cpr_pkg::SEL_OBJ_INDEX, 8'h40, 1'b1, 8'h00},
		'{cpr_pkg::KIND_WRITE, cpr_pkg::SEL_OBJ_INDEX, 8'hC0, 1'b1, 8'h80},
		'{cpr_pkg::KIND_WRITE, cpr_pkg::SEL_OBJ_DATA,  8'hA5, 1'b0, 8'h00},
		'{cpr_pkg::KIND_WRITE, cpr_pkg::SEL_OBJ_DATA,  8'h5A, 1'b0, 8'h00},
		'{cpr_pkg::KIND_WRITE, cpr_pkg::SEL_OBJ_INDEX, 8'h00, 1'b1, 8'h00},
		'{cpr_pkg::KIND_READ,  cpr_pkg::SEL_OBJ_DATA,  8'h00, 1'b0, 8'h00},
		'{cpr_pkg::KIND_WRITE, cpr_pkg::SEL_OBJ_INDEX, 8'h7E, 1'b1, 8'h3E},
		'{cpr_pkg::KIND_WRITE, cpr_pkg::SEL_OBJ_DATA,  8'h00, 1'b1, 8'h00},
		'{cpr_pkg::KIND_WRITE, cpr_pkg::SEL_BG_DATA,   8'h80, 1'b0, 8'h00}
	};

	logic clk;
	logic arst_n;

	cpr_req_if req_ch ();
	cpr_rsp_if rsp_ch ();

	color_palette_ram_port DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// palette model: index 0 background, 1 object
	logic [14:0] pal_mem [2][cpr_pkg::PAL_DEPTH];
	logic [7:0]  pal_index [2];
	logic [7:0]  pal_data [2];

	logic [7:0] read_expect [$];
	logic [7:0] want_byte;
	int sent;
	int checked;
	int errors;
	int auto_steps;
	int wraps;
	bit calm;

	function automatic void load_index(int p, logic [7:0] v);
		logic [14:0] e;
		e = pal_mem[p][v[5:1]];
		pal_index[p] = v & cpr_pkg::INDEX_KEEP;
		pal_data[p] = v[cpr_pkg::HIGH_SEL_BIT] ? {1'b0, e[14:8]} : e[7:0];
	endfunction

	function automatic void store_byte(int p, logic [7:0] v);
		logic [4:0] i;
		i = pal_index[p][5:1];
		pal_data[p] = v;
		if (pal_index[p][cpr_pkg::HIGH_SEL_BIT]) begin
			pal_mem[p][i][14:8] = v[6:0];
		end else begin
			pal_mem[p][i][7:0] = v;
		end
		if (pal_index[p][cpr_pkg::AUTO_INC_BIT]) begin
			auto_steps++;
			if (pal_index[p][5:0] == 6'h3F) begin
				wraps++;
			end
			load_index(p, pal_index[p] + 8'd1);
		end
	endfunction

	function automatic logic [7:0] predict_access(cpr_pkg::kind_t k, cpr_pkg::reg_sel_t s,
			logic [7:0] v);
		int p;
		p = s[1];
		if (k == cpr_pkg::KIND_WRITE) begin
			if (s[0]) begin
				store_byte(p, v);
			end else begin
				load_index(p, v);
			end
		end
		return s[0] ? pal_data[p] : pal_index[p];
	endfunction

	function automatic bit quiet_stretch();
		return calm || ((sent / 250) % 3 == 2);
	endfunction

	task automatic send_request(cpr_pkg::kind_t k, cpr_pkg::reg_sel_t s, logic [7:0] v,
			logic typed, logic [7:0] want);
		logic [7:0] pred;
		if (!quiet_stretch() && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= k;
		req_ch.reg_select <= s;
		req_ch.write_data <= v;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		pred = predict_access(k, s, v);
		read_expect.push_back(typed ? want : pred);
		sent++;
	endtask

	task automatic drain_responses();
		req_ch.valid <= 1'b0;
		while (read_expect.size() != 0) @(posedge clk);
	endtask

	// index write then a run of data writes, mostly with auto-increment
	task automatic run_stream();
		int p;
		int n;
		logic [7:0] idx;
		p = $urandom_range(0, 1);
		idx = 8'($urandom);
		if ($urandom_range(0, 3) != 0) begin
			idx[cpr_pkg::AUTO_INC_BIT] = 1'b1;
		end
		send_request(cpr_pkg::KIND_WRITE, cpr_pkg::reg_sel_t'({p[0], 1'b0}), idx, 1'b0,
			8'h00);
		n = $urandom_range(1, 40);
		repeat (n) begin
			if ($urandom_range(0, 7) == 0) begin
				send_request(cpr_pkg::KIND_READ,
					cpr_pkg::reg_sel_t'({p[0], 1'($urandom_range(0, 1))}),
					8'($urandom), 1'b0, 8'h00);
			end else begin
				send_request(cpr_pkg::KIND_WRITE, cpr_pkg::reg_sel_t'({p[0], 1'b1}),
					8'($urandom), 1'b0, 8'h00);
			end
		end
	endtask

	task automatic run_readback();
		int p;
		logic [7:0] idx;
		p = $urandom_range(0, 1);
		idx = 8'($urandom);
		if ($urandom_range(0, 3) != 0) begin
			idx[cpr_pkg::AUTO_INC_BIT] = 1'b0;
		end
		send_request(cpr_pkg::KIND_WRITE, cpr_pkg::reg_sel_t'({p[0], 1'b0}), idx, 1'b0,
			8'h00);
		repeat ($urandom_range(1, 3)) begin
			send_request(cpr_pkg::KIND_READ, cpr_pkg::reg_sel_t'({p[0], 1'b1}),
				8'($urandom), 1'b0, 8'h00);
		end
	endtask

	task automatic run_noise();
		repeat ($urandom_range(1, 8)) begin
			send_request(cpr_pkg::kind_t'($urandom_range(0, 1)),
				cpr_pkg::reg_sel_t'($urandom_range(0, 3)), 8'($urandom), 1'b0, 8'h00);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("%0t: timeout, %0d responses still outstanding", $time, read_expect.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet_stretch() && $urandom_range(0, 6) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (read_expect.size() == 0) begin
				$display("%0t: response with nothing outstanding, expected none, actual %02h",
					$time, rsp_ch.read_data);
				errors++;
			end else begin
				want_byte = read_expect.pop_front();
				checked++;
				if (rsp_ch.read_data !== want_byte) begin
					$display("%0t: read_data mismatch, expected %02h, actual %02h",
						$time, want_byte, rsp_ch.read_data);
					errors++;
				end
			end
		end
	end

	initial begin
		int next_drain;
		int pick;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.kind <= cpr_pkg::KIND_READ;
		req_ch.reg_select <= cpr_pkg::SEL_BG_INDEX;
		req_ch.write_data <= 8'h00;
		for (int p = 0; p < 2; p++) begin
			pal_index[p] = 8'h00;
			pal_data[p] = 8'h00;
			for (int e = 0; e < cpr_pkg::PAL_DEPTH; e++) begin
				pal_mem[p][e] = 15'h0000;
			end
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_COUNT; r++) begin
			send_request(DIR_ROWS[r].kind, DIR_ROWS[r].sel, DIR_ROWS[r].wdata,
				DIR_ROWS[r].typed, DIR_ROWS[r].want);
		end
		drain_responses();
		@(posedge clk);

		next_drain = sent + 600;
		while (sent < DIR_COUNT + RANDOM_REQUESTS) begin
			if (sent > DIR_COUNT + RANDOM_REQUESTS - 200) begin
				calm = 1'b1;
			end
			if (sent >= next_drain) begin
				drain_responses();
				@(posedge clk);
				next_drain = sent + 600;
			end
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				run_stream();
			end else if (pick < 8) begin
				run_readback();
			end else begin
				run_noise();
			end
		end
		req_ch.valid <= 1'b0;
		while (read_expect.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("requests %0d, responses checked %0d, mismatches %0d", sent, checked, errors);
		$display("auto-increment steps %0d, index wraps %0d", auto_steps, wraps);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
